>>> sv/flptm_pkg.sv
// ----------------------------------------------------------------------------
// flptm_pkg
// Shared constants, status codes and transfer types for the page table mapper.
// ----------------------------------------------------------------------------
package flptm_pkg;

  // Store geometry
  localparam int POOL_PAGES        = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int STORE_PAGES       = POOL_PAGES + 1;
  localparam int STORE_DEPTH       = STORE_PAGES * ENTRIES_PER_TABLE;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W            = $clog2(STORE_PAGES);
  localparam int ADDR_W            = PAGE_W + IDX_W;

  // Field widths
  localparam int PA_W     = 52;
  localparam int VA_W     = 48;
  localparam int FLAG_W   = 12;
  localparam int STAT_W   = 2;
  localparam int USED_W   = 7;
  localparam int RPAGE_W  = PA_W - 12;
  // A pointer entry holds (root + page * 4096): one bit above the physical width
  localparam int ENTRY_W  = PA_W + 1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_POOL = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

  // Reset value of the root table address
  localparam logic [PA_W-1:0] TABLE_BASE_RST = 52'h0_0000_0010_F000;

  typedef struct packed {
    logic [FLAG_W-1:0] page_flags;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
  } req_t;

  typedef struct packed {
    logic [USED_W-1:0] tables_used;
    logic [PA_W-1:0]   leaf_entry;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

>>> sv/flptm_ram.sv
// ----------------------------------------------------------------------------
// flptm_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module flptm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/flptm_walker.sv
// ----------------------------------------------------------------------------
// flptm_walker
// Table store plus the walk sequencer: clears the store after reset, then
// reads, allocates and writes back one level per step for each request.
// ----------------------------------------------------------------------------
module flptm_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [flptm_pkg::RPAGE_W-1:0] root_page,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  flptm_pkg::req_t               req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output flptm_pkg::res_t               res
);
  import flptm_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [1:0] LVL_LAST = 2'd2;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [1:0]         lvl_r, lvl_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [PAGE_W-1:0]  cnt_r, cnt_nxt;
  req_t               req_r, req_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [PA_W-1:0]    leaf_r, leaf_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic [IDX_W-1:0]   lvl_idx;
  logic [ADDR_W-1:0]  walk_addr;
  logic [PAGE_W-1:0]  new_page;
  logic [ENTRY_W-1:0] ptr_entry;
  logic [PA_W-1:0]    leaf_val;
  logic [RPAGE_W+1:0] pg_diff;
  logic               ptr_outside;

  flptm_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Entry index for the current level
  always_comb begin
    case (lvl_r)
      2'd0:    lvl_idx = req_r.virt_addr[47:39];
      2'd1:    lvl_idx = req_r.virt_addr[38:30];
      default: lvl_idx = req_r.virt_addr[29:21];
    endcase
  end

  assign walk_addr = {page_r, lvl_idx};
  assign new_page  = cnt_r + PAGE_W'(1);
  assign ptr_entry = {({1'b0, root_page} + (RPAGE_W + 1)'(new_page)),
                      9'd0, req_r.page_flags[2], 2'b11};
  assign leaf_val  = {req_r.phys_addr[PA_W-1:12], req_r.page_flags[FLAG_W-1:1], 1'b1};

  // Locate the page that a present entry points to
  assign pg_diff     = {1'b0, mem_rdata[ENTRY_W-1:12]} - {2'b00, root_page};
  assign ptr_outside = pg_diff[RPAGE_W+1]
                    || (pg_diff[RPAGE_W:0] >= (RPAGE_W + 1)'(STORE_PAGES));

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    lvl_nxt    = lvl_r;
    page_nxt   = page_r;
    cnt_nxt    = cnt_r;
    req_nxt    = req_r;
    status_nxt = status_r;
    leaf_nxt   = leaf_r;
    mem_we     = 1'b0;
    mem_waddr  = walk_addr;
    mem_wdata  = ptr_entry;
    mem_re     = 1'b0;
    mem_raddr  = walk_addr;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = req;
          lvl_nxt   = 2'd0;
          page_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!mem_rdata[0]) begin
          if (cnt_r >= PAGE_W'(POOL_PAGES)) begin
            status_nxt = ST_NO_POOL;
            leaf_nxt   = '0;
            state_nxt  = S_DONE;
          end else begin
            // Link a fresh pool page in place of the empty entry
            mem_we    = 1'b1;
            cnt_nxt   = new_page;
            page_nxt  = new_page;
            state_nxt = (lvl_r == LVL_LAST) ? S_LEAF : S_RD;
            lvl_nxt   = lvl_r + 2'd1;
          end
        end else if (ptr_outside) begin
          status_nxt = ST_OUTSIDE;
          leaf_nxt   = '0;
          state_nxt  = S_DONE;
        end else begin
          page_nxt  = pg_diff[PAGE_W-1:0];
          state_nxt = (lvl_r == LVL_LAST) ? S_LEAF : S_RD;
          lvl_nxt   = lvl_r + 2'd1;
        end
      end
      S_LEAF: begin
        mem_we     = 1'b1;
        mem_waddr  = {page_r, req_r.virt_addr[20:12]};
        mem_wdata  = ENTRY_W'(leaf_val);
        status_nxt = ST_OK;
        leaf_nxt   = leaf_val;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status      = status_r;
  assign res.leaf_entry  = leaf_r;
  assign res.tables_used = USED_W'(cnt_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    lvl_r    <= lvl_nxt;
    page_r   <= page_nxt;
    req_r    <= req_nxt;
    status_r <= status_nxt;
    leaf_r   <= leaf_nxt;
  end

endmodule

>>> sv/four_level_page_table_mapper.sv
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Maps one 4 KiB virtual page per request into a four-level table store.
// ----------------------------------------------------------------------------
// After reset the block clears its 33280-entry table store, one entry per
// cycle, and accepts no request until the store is clear; the table_base
// port takes writes at any time. A request that reaches the leaf is
// accepted, then read and evaluated at each of the three upper levels
// through the single registered read port of the store, then the leaf is
// written and the result is handed to the output register. Failing
// requests finish earlier. A new request is taken while the previous
// result still waits on the output.
module four_level_page_table_mapper (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration: table_base
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [flptm_pkg::PA_W-1:0] cfg_data,
  // Requests
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [111:0]               in_tdata,   // phys_addr, virt_addr, page_flags
  // Results
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,  // leaf_entry, tables_used, zero fill
  output logic [1:0]                 out_tuser   // status
);
  import flptm_pkg::*;

  logic [PA_W-1:0] base_r;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_r;
  req_t            req;
  res_t            res;
  logic            res_valid;
  logic            res_ready;

  // Hold table_base
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= TABLE_BASE_RST;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  assign req = req_t'(in_tdata);

  flptm_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .root_page (base_r[PA_W-1:12]),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.tables_used, out_r.leaf_entry};
  assign out_tuser  = out_r.status;

`ifndef SYNTHESIS
  // A failed request reports an empty leaf
  a_fail_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[PA_W-1:0] == '0))
    else $error("failed request carries a nonzero leaf entry");

  // A written leaf is always present
  a_leaf_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK) |-> out_tdata[0])
    else $error("mapped leaf entry lacks the present bit");

  // The pool count never passes the pool size
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PA_W+USED_W-1:PA_W] <= USED_W'(POOL_PAGES)))
    else $error("tables_used exceeds the pool size");

  // A walk occupies the sequencer after a transfer is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while a walk is in progress");
`endif

endmodule
